>>> design/lcdx_pkg.sv
`default_nettype none

package lcdx_pkg;

    // expander byte and number constants
    localparam logic       EXP_BACKLIGHT = 1'b1;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam int         MAX_DIGITS    = 5;
    localparam int         POS_W         = 3;
    localparam int         PC_W          = 4;

    // opcodes
    typedef enum logic [1:0] {
        OP_NYBBLE  = 2'd0,
        OP_COMMAND = 2'd1,
        OP_DATA    = 2'd2,
        OP_NUMBER  = 2'd3
    } t_opcode;

    // datapath action of one control word
    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_SUB,
        ACT_DECIDE,
        ACT_NEXT,
        ACT_EMIT
    } t_act;

    // sequencing condition of one control word
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_WAIT,
        COND_DISPATCH,
        COND_DONE,
        COND_GE,
        COND_SHOW
    } t_cond;

    typedef struct packed {
        t_act             act;
        logic             nyb_hi;
        logic             enable;
        logic             last;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_cword;

    // control from sequencer to datapath
    typedef struct packed {
        t_act act;
        logic go;
        logic nyb_hi;
        logic enable;
        logic last;
    } t_dp_ctrl;

    // status from datapath to sequencer
    typedef struct packed {
        t_opcode op;
        logic    ge;
        logic    show;
        logic    pos_zero;
    } t_dp_status;

    // program addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] PC_HI0      = 4'd2;
    localparam logic [PC_W-1:0] PC_HI1      = 4'd3;
    localparam logic [PC_W-1:0] PC_HI2      = 4'd4;
    localparam logic [PC_W-1:0] PC_LO0      = 4'd5;
    localparam logic [PC_W-1:0] PC_LO1      = 4'd6;
    localparam logic [PC_W-1:0] PC_LO2      = 4'd7;
    localparam logic [PC_W-1:0] PC_NEXT     = 4'd8;
    localparam logic [PC_W-1:0] PC_SUB      = 4'd9;
    localparam logic [PC_W-1:0] PC_DECIDE   = 4'd10;
    localparam logic [PC_W-1:0] PC_SKIP     = 4'd11;

    // power of ten for a digit position
    function automatic logic [15:0] pow10(input logic [POS_W-1:0] pos);
        logic [15:0] p;
        case (pos)
            3'd0:    p = 16'd1;
            3'd1:    p = 16'd10;
            3'd2:    p = 16'd100;
            3'd3:    p = 16'd1000;
            3'd4:    p = 16'd10000;
            default: p = 16'd1;
        endcase
        return p;
    endfunction

    // control store
    function automatic t_cword ucode(input logic [PC_W-1:0] pc);
        t_cword w;
        w = '{act: ACT_NOP, nyb_hi: 1'b0, enable: 1'b0, last: 1'b0,
              cond: COND_ALWAYS, target: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                w.act  = ACT_ACCEPT;
                w.cond = COND_WAIT;
            end
            PC_DISPATCH: begin
                w.cond = COND_DISPATCH;
            end
            PC_HI0: begin
                w.act    = ACT_EMIT;
                w.nyb_hi = 1'b1;
                w.cond   = COND_NEXT;
            end
            PC_HI1: begin
                w.act    = ACT_EMIT;
                w.nyb_hi = 1'b1;
                w.enable = 1'b1;
                w.cond   = COND_NEXT;
            end
            PC_HI2: begin
                w.act    = ACT_EMIT;
                w.nyb_hi = 1'b1;
                w.cond   = COND_NEXT;
            end
            PC_LO0: begin
                w.act  = ACT_EMIT;
                w.cond = COND_NEXT;
            end
            PC_LO1: begin
                w.act    = ACT_EMIT;
                w.enable = 1'b1;
                w.cond   = COND_NEXT;
            end
            PC_LO2: begin
                w.act    = ACT_EMIT;
                w.last   = 1'b1;
                w.cond   = COND_DONE;
                w.target = PC_IDLE;
            end
            PC_NEXT: begin
                w.act    = ACT_NEXT;
                w.target = PC_SUB;
            end
            PC_SUB: begin
                w.act    = ACT_SUB;
                w.cond   = COND_GE;
                w.target = PC_SUB;
            end
            PC_DECIDE: begin
                w.act    = ACT_DECIDE;
                w.cond   = COND_SHOW;
                w.target = PC_HI0;
            end
            PC_SKIP: begin
                w.target = PC_NEXT;
            end
            default: begin
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> design/char_lcd_expander_encoder_top.sv
// a transaction is taken in the idle step, then dispatched on its opcode; each expander
// byte goes through the output register, and an emit step holds while it is full and not
// taken; a raw nybble is three writes, a byte six; a number takes digit extraction and
// stepping per digit position, then sends each shown digit; one transaction is handled at a time
// reset (synchronous, active low) returns the step counter to idle and empties the output
`default_nettype none

module char_lcd_expander_encoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [15:0] i_number_value,
    input  wire logic [2:0]  i_digit_count,
    input  wire logic        i_show_leading_zeros,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_expander_byte,
    output logic             o_last
);

    logic [lcdx_pkg::PC_W-1:0] r_pc;
    logic [lcdx_pkg::PC_W-1:0] n_pc;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;

    lcdx_pkg::t_cword          cw;
    lcdx_pkg::t_dp_ctrl        ctrl;
    lcdx_pkg::t_dp_status      status;
    logic                      stall;
    logic                      go;
    logic                      accepted;
    logic                      emit;
    logic [7:0]                dp_byte;
    logic                      dp_last;

    // control word fetch and handshake
    always_comb begin
        cw         = lcdx_pkg::ucode(r_pc);
        o_in_ready = (cw.act == lcdx_pkg::ACT_ACCEPT);
        accepted   = i_in_valid && o_in_ready;
        stall      = (cw.act == lcdx_pkg::ACT_EMIT) && r_out_valid && !i_out_ready;
        go         = (cw.act == lcdx_pkg::ACT_ACCEPT) ? accepted : !stall;
        emit       = (cw.act == lcdx_pkg::ACT_EMIT) && go;
        ctrl       = '{act: cw.act, go: go, nyb_hi: cw.nyb_hi,
                       enable: cw.enable, last: cw.last};
    end

    // step sequencing
    always_comb begin
        n_pc = r_pc;
        if (go) begin
            unique case (cw.cond)
                lcdx_pkg::COND_NEXT:   n_pc = r_pc + 4'd1;
                lcdx_pkg::COND_ALWAYS: n_pc = cw.target;
                lcdx_pkg::COND_WAIT:   n_pc = r_pc + 4'd1;
                lcdx_pkg::COND_DISPATCH: begin
                    unique case (status.op)
                        lcdx_pkg::OP_NYBBLE: n_pc = lcdx_pkg::PC_LO0;
                        lcdx_pkg::OP_NUMBER: n_pc = lcdx_pkg::PC_SUB;
                        default:             n_pc = lcdx_pkg::PC_HI0;
                    endcase
                end
                lcdx_pkg::COND_DONE: begin
                    if ((status.op != lcdx_pkg::OP_NUMBER) || status.pos_zero) begin
                        n_pc = cw.target;
                    end else begin
                        n_pc = r_pc + 4'd1;
                    end
                end
                lcdx_pkg::COND_GE:   n_pc = status.ge ? cw.target : r_pc + 4'd1;
                lcdx_pkg::COND_SHOW: n_pc = status.show ? cw.target : r_pc + 4'd1;
                default:             n_pc = lcdx_pkg::PC_IDLE;
            endcase
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lcdx_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    lcdx_datapath u_datapath (
        .i_clk                (i_clk),
        .i_ctrl               (ctrl),
        .i_opcode             (i_opcode),
        .i_byte_value         (i_byte_value),
        .i_number_value       (i_number_value),
        .i_digit_count        (i_digit_count),
        .i_show_leading_zeros (i_show_leading_zeros),
        .o_status             (status),
        .o_byte               (dp_byte),
        .o_last               (dp_last)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= dp_byte;
            r_out_last <= dp_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expander_byte = r_out_byte;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

>>> design/lcdx_datapath.sv
`default_nettype none

module lcdx_datapath (
    input  wire logic                  i_clk,
    input  wire lcdx_pkg::t_dp_ctrl    i_ctrl,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic [15:0]           i_number_value,
    input  wire logic [2:0]            i_digit_count,
    input  wire logic                  i_show_leading_zeros,
    output lcdx_pkg::t_dp_status       o_status,
    output logic [7:0]                 o_byte,
    output logic                       o_last
);

    logic [1:0]                  r_op;
    logic [7:0]                  r_byte;
    logic [15:0]                 r_value;
    logic [lcdx_pkg::POS_W-1:0]  r_pos;
    logic [lcdx_pkg::POS_W-1:0]  r_dc;
    logic [3:0]                  r_digit;
    logic                        r_seen;

    logic [15:0]                 pw;
    logic                        ge;
    logic                        in_range;
    logic                        nonzero;
    logic                        show;
    logic [lcdx_pkg::POS_W-1:0]  dc_clamped;
    logic [3:0]                  nyb;
    logic                        rs;
    logic                        pos_zero;

    // digit position helpers
    always_comb begin
        pw       = lcdx_pkg::pow10(r_pos);
        ge       = (r_value >= pw);
        pos_zero = (r_pos == '0);
        in_range = (r_pos < r_dc);
        nonzero  = (r_digit != 4'd0) || pos_zero;
        show     = in_range && (r_seen || nonzero);
    end

    // clamp digit count to 1..5
    always_comb begin
        if (i_digit_count == 3'd0) begin
            dc_clamped = 3'd1;
        end else if (i_digit_count > 3'(lcdx_pkg::MAX_DIGITS)) begin
            dc_clamped = 3'(lcdx_pkg::MAX_DIGITS);
        end else begin
            dc_clamped = i_digit_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.go) begin
            case (i_ctrl.act)
                lcdx_pkg::ACT_ACCEPT: begin
                    r_op    <= i_opcode;
                    r_byte  <= i_byte_value;
                    r_value <= i_number_value;
                    r_dc    <= dc_clamped;
                    r_pos   <= 3'(lcdx_pkg::MAX_DIGITS - 1);
                    r_digit <= 4'd0;
                    r_seen  <= i_show_leading_zeros;
                end
                lcdx_pkg::ACT_SUB: begin
                    if (ge) begin
                        r_value <= r_value - pw;
                        r_digit <= r_digit + 4'd1;
                    end
                end
                lcdx_pkg::ACT_DECIDE: begin
                    if (in_range && nonzero) begin
                        r_seen <= 1'b1;
                    end
                    r_byte <= lcdx_pkg::ASCII_ZERO + {4'd0, r_digit};
                end
                lcdx_pkg::ACT_NEXT: begin
                    r_pos   <= r_pos - 3'd1;
                    r_digit <= 4'd0;
                end
                default: begin
                end
            endcase
        end
    end

    // expander byte: nybble, backlight, enable, rw low, rs
    always_comb begin
        nyb    = i_ctrl.nyb_hi ? r_byte[7:4] : r_byte[3:0];
        rs     = r_op[1];
        o_byte = {nyb, lcdx_pkg::EXP_BACKLIGHT, i_ctrl.enable, 1'b0, rs};
        o_last = i_ctrl.last &&
                 ((r_op != lcdx_pkg::OP_NUMBER) || pos_zero);
    end

    assign o_status = '{op: lcdx_pkg::t_opcode'(r_op), ge: ge, show: show,
                        pos_zero: pos_zero};

endmodule

`default_nettype wire

>>> tb/expander_byte_checker.sv
`default_nettype none

module expander_byte_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic [15:0] i_number_value,
    input  wire logic [2:0]  i_digit_count,
    input  wire logic        i_show_leading_zeros,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [7:0]  i_expander_byte,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending
);

    localparam logic [7:0] ENABLE_BIT = 8'h04;

    typedef struct packed {
        logic [7:0] xbyte;
        logic       last;
    } t_lcd_beat;

    // expander writes still owed by the block, oldest first
    t_lcd_beat expected_beats[$];
    int        mismatches = 0;

    // one nybble: enable low, high, low
    function automatic void queue_nybble(input logic [3:0] nyb, input logic rs);
        logic [7:0] base;
        base = {nyb, lcdx_pkg::EXP_BACKLIGHT, 1'b0, 1'b0, rs};
        expected_beats.push_back('{xbyte: base, last: 1'b0});
        expected_beats.push_back('{xbyte: base | ENABLE_BIT, last: 1'b0});
        expected_beats.push_back('{xbyte: base, last: 1'b0});
    endfunction

    // full byte, high nybble first
    function automatic void queue_lcd_byte(input logic [7:0] value, input logic rs);
        queue_nybble(value[7:4], rs);
        queue_nybble(value[3:0], rs);
    endfunction

    // expected expander writes for one request
    function automatic void predict_expander_writes(
        input logic [1:0]  op,
        input logic [7:0]  bval,
        input logic [15:0] nval,
        input logic [2:0]  dcount,
        input logic        zeros
    );
        int unsigned positions;
        int unsigned value;
        int unsigned scale;
        int unsigned digit;
        int          d;
        logic        seen;
        logic [7:0]  ch;
        t_lcd_beat   tail;
        case (lcdx_pkg::t_opcode'(op))
            lcdx_pkg::OP_NYBBLE: begin
                queue_nybble(bval[3:0], 1'b0);
            end
            lcdx_pkg::OP_COMMAND: begin
                queue_lcd_byte(bval, 1'b0);
            end
            lcdx_pkg::OP_DATA: begin
                queue_lcd_byte(bval, 1'b1);
            end
            default: begin
                // digit count clamps to 1..5, value wraps at the display width
                if (dcount == 3'd0) begin
                    positions = 1;
                end else if (dcount > lcdx_pkg::MAX_DIGITS) begin
                    positions = lcdx_pkg::MAX_DIGITS;
                end else begin
                    positions = dcount;
                end
                scale = 1;
                for (d = 1; d < positions; d++) scale = scale * 10;
                value = nval % (scale * 10);
                seen = zeros;
                for (d = positions; d > 0; d--) begin
                    digit = value / scale;
                    value = value - digit * scale;
                    // units digit always shown
                    if (digit != 0 || d == 1) seen = 1'b1;
                    if (seen) begin
                        ch = lcdx_pkg::ASCII_ZERO + digit[7:0];
                        queue_lcd_byte(ch, 1'b1);
                    end
                    scale = scale / 10;
                end
            end
        endcase
        // flag the final write of the transaction
        tail = expected_beats.pop_back();
        tail.last = 1'b1;
        expected_beats.push_back(tail);
    endfunction

    // watch both channels
    always @(posedge i_clk) begin
        t_lcd_beat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                predict_expander_writes(i_opcode, i_byte_value, i_number_value,
                                        i_digit_count, i_show_leading_zeros);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected write: expected none, actual byte %02h last %0b",
                             $time, i_expander_byte, i_last);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_expander_byte !== want.xbyte) begin
                        mismatches++;
                        $display("%0t: expander byte: expected %02h, actual %02h",
                                 $time, want.xbyte, i_expander_byte);
                    end
                    if (i_last !== want.last) begin
                        mismatches++;
                        $display("%0t: last: expected %0b, actual %0b",
                                 $time, want.last, i_last);
                    end
                end
            end
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQUESTS = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  byte_value;
    logic [15:0] number_value;
    logic [2:0]  digit_count;
    logic        show_zeros;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  expander_byte;
    logic        last;
    logic        throttle;
    int          cycles = 0;
    int          fail_count;
    int          pending;

    char_lcd_expander_encoder_top dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_opcode             (opcode),
        .i_byte_value         (byte_value),
        .i_number_value       (number_value),
        .i_digit_count        (digit_count),
        .i_show_leading_zeros (show_zeros),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_expander_byte      (expander_byte),
        .o_last               (last)
    );

    expander_byte_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_opcode             (opcode),
        .i_byte_value         (byte_value),
        .i_number_value       (number_value),
        .i_digit_count        (digit_count),
        .i_show_leading_zeros (show_zeros),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_expander_byte      (expander_byte),
        .i_last               (last),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= !(throttle && ($urandom_range(99) < 22));
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one transaction on the request channel, with random idle cycles ahead of it
    task automatic send_request(input lcdx_pkg::t_opcode op, input logic [7:0] bval,
                                input logic [15:0] nval, input logic [2:0] dcount,
                                input logic zeros);
        while (throttle && ($urandom_range(99) < 22)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        byte_value   <= bval;
        number_value <= nval;
        digit_count  <= dcount;
        show_zeros   <= zeros;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_request();
        lcdx_pkg::t_opcode op;
        logic [15:0]       nval;
        logic [2:0]        dcount;
        op = lcdx_pkg::t_opcode'($urandom_range(0, 3));
        // short numbers half the time so suppression and wrap both show up
        case ($urandom_range(0, 3))
            0:       nval = 16'($urandom_range(0, 9));
            1:       nval = 16'($urandom_range(0, 999));
            default: nval = 16'($urandom_range(0, 65535));
        endcase
        // digit counts outside 1..5 now and then
        if ($urandom_range(0, 9) == 0) dcount = 3'($urandom_range(0, 7));
        else dcount = 3'($urandom_range(1, 5));
        send_request(op, 8'($urandom_range(0, 255)), nval, dcount,
                     1'($urandom_range(0, 1)));
    endtask

    // hold the request channel until every write has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // stimulus and verdict
    initial begin
        int k;
        in_valid     = 1'b0;
        opcode       = lcdx_pkg::OP_NYBBLE;
        byte_value   = 8'h00;
        number_value = 16'h0000;
        digit_count  = 3'd1;
        show_zeros   = 1'b0;
        out_ready    = 1'b0;
        throttle     = 1'b1;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: nybble, command and data opcodes with extreme bytes
        send_request(lcdx_pkg::OP_NYBBLE,  8'h00, 16'hffff, 3'd5, 1'b1);
        send_request(lcdx_pkg::OP_NYBBLE,  8'hff, 16'h0000, 3'd0, 1'b0);
        send_request(lcdx_pkg::OP_NYBBLE,  8'ha5, 16'h1234, 3'd7, 1'b1);
        send_request(lcdx_pkg::OP_COMMAND, 8'h00, 16'hffff, 3'd3, 1'b0);
        send_request(lcdx_pkg::OP_COMMAND, 8'hff, 16'h0000, 3'd2, 1'b1);
        send_request(lcdx_pkg::OP_COMMAND, 8'h5a, 16'h5555, 3'd1, 1'b0);
        send_request(lcdx_pkg::OP_DATA,    8'h00, 16'haaaa, 3'd4, 1'b1);
        send_request(lcdx_pkg::OP_DATA,    8'hff, 16'h0000, 3'd6, 1'b0);
        send_request(lcdx_pkg::OP_DATA,    8'ha5, 16'hffff, 3'd5, 1'b1);
        // directed: numbers, zero and full scale
        send_request(lcdx_pkg::OP_NUMBER,  8'hff, 16'd0,     3'd5, 1'b0);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd0,     3'd5, 1'b1);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd65535, 3'd5, 1'b0);
        send_request(lcdx_pkg::OP_NUMBER,  8'hff, 16'd65535, 3'd5, 1'b1);
        // number wider than the digit count wraps
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd12345, 3'd3, 1'b0);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd1000,  3'd1, 1'b0);
        // single digit with and without leading zeros
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd7,     3'd5, 1'b0);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd7,     3'd5, 1'b1);
        // inner zeros are not leading zeros
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd100,   3'd3, 1'b0);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd10000, 3'd5, 1'b0);
        // digit count zero and above five
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd9876,  3'd0, 1'b1);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd54321, 3'd6, 1'b0);
        send_request(lcdx_pkg::OP_NUMBER,  8'h00, 16'd305,   3'd7, 1'b1);
        wait_drained();

        // random part, with a stretch of back-to-back traffic and a full drain
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            throttle = !(k >= 70 && k < 120);
            if (k == 140) wait_drained();
            send_random_request();
        end
        throttle = 1'b1;
        wait_drained();
        repeat (40) @(posedge clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/lcdx_pkg.sv
design/lcdx_datapath.sv
design/char_lcd_expander_encoder_top.sv
tb/expander_byte_checker.sv
tb/tb.sv
